### hw/rtl/sorted_table_search_top_assert.svh
// ---------------------------------------------------------------------------
// sorted_table_search_top_assert.svh
// Assertion macros shared by the checker of the sorted table search block.
// ---------------------------------------------------------------------------
`ifndef SORTED_TABLE_SEARCH_TOP_ASSERT_SVH
`define SORTED_TABLE_SEARCH_TOP_ASSERT_SVH

// antecedent and consequent in the same cycle
`define STS_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("sts assertion failed");

// consequent in the cycle after the antecedent
`define STS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("sts assertion failed");

`endif

### hw/rtl/sts_pkg.sv
// ---------------------------------------------------------------------------
// sts_pkg
// Types and constants of the sorted table search block.
// ---------------------------------------------------------------------------
package sts_pkg;

    localparam int DATA_W = 32;

    typedef enum logic [1:0] {
        CMD_CLEAR  = 2'd0,
        CMD_INSERT = 2'd1,
        CMD_SORT   = 2'd2,
        CMD_SEARCH = 2'd3
    } t_cmd;

    typedef struct packed {
        t_cmd                     cmd;
        logic signed [DATA_W-1:0] value;
    } t_item;

    typedef struct packed {
        logic found;
        logic status;
    } t_result;

    typedef struct packed {
        logic eq;
        logic gt;
    } t_cmp;

endpackage

### hw/rtl/sorted_table_search_top.sv
// ---------------------------------------------------------------------------
// sorted_table_search_top
// Table of signed words with clear, append, bubble sort and binary search.
//
//   channel  | handshake            | word
//   ---------+----------------------+----------------------------
//   command  | start in, busy out   | i_item   (cmd, value)
//   result   | o_strobe out         | o_result (found, status)
//
// Clear, insert, search of an empty table and sort of fewer than two entries:
// result in the cycle after start.
// Search: S_PROBE then S_PCMP per probe, at most clog2(DEPTH)+1 probes.
// Sort: S_SLOAD, then S_SCMP per compare, then S_SEND per pass; passes stop
// after one without a swap or once the last pair has been compared.
// Reset clears state, fill and strobe only; the table needs no clearing pass.
// The strobe lasts one cycle; busy holds off start during search and sort.
// ---------------------------------------------------------------------------
module sorted_table_search_top
    import sts_pkg::*;
#(
    parameter int DEPTH = 256
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    start,
    output logic    busy,
    input  t_item   i_item,
    output logic    o_strobe,
    output t_result o_result
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_SLOAD = 6'b000010,
        S_SCMP  = 6'b000100,
        S_SEND  = 6'b001000,
        S_PROBE = 6'b010000,
        S_PCMP  = 6'b100000
    } t_state;

    t_state r_state, n_state;
    logic [CW-1:0] r_fill, n_fill;
    logic [AW-1:0] r_idx, n_idx;
    logic [AW-1:0] r_lim, n_lim;
    logic [AW-1:0] r_mid, n_mid;
    logic [CW-1:0] r_lo, n_lo;
    logic [CW-1:0] r_hi, n_hi;
    logic signed [DATA_W-1:0] r_opnd, n_opnd;
    logic r_swap, n_swap;
    logic r_strobe, n_strobe;
    t_result r_res, n_res;

    logic signed [DATA_W-1:0] mem [DEPTH];
    logic signed [DATA_W-1:0] r_rdata;
    logic [AW-1:0] rd_addr;
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic signed [DATA_W-1:0] wr_data;

    t_cmp          cmp;
    logic [AW-1:0] idx_nx;
    logic [CW-1:0] fill_m1;
    logic [CW:0]   mid_sum;
    logic [CW-1:0] lo_nx;

    sts_cmp u_cmp (
        .i_a   (r_opnd),
        .i_b   (r_rdata),
        .o_cmp (cmp)
    );

    assign idx_nx  = r_idx + AW'(1);
    assign fill_m1 = r_fill - CW'(1);
    assign mid_sum = {1'b0, r_lo} + {1'b0, r_hi} - (CW+1)'(1);
    assign lo_nx   = CW'(r_mid) + CW'(1);

    always_comb begin
        n_state  = r_state;
        n_fill   = r_fill;
        n_idx    = r_idx;
        n_lim    = r_lim;
        n_mid    = r_mid;
        n_lo     = r_lo;
        n_hi     = r_hi;
        n_opnd   = r_opnd;
        n_swap   = r_swap;
        n_strobe = 1'b0;
        n_res    = r_res;
        rd_addr  = '0;
        wr_en    = 1'b0;
        wr_addr  = '0;
        wr_data  = r_rdata;
        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_res = '0;
                    unique case (i_item.cmd)
                        CMD_CLEAR: begin
                            n_fill   = '0;
                            n_strobe = 1'b1;
                        end
                        CMD_INSERT: begin
                            n_strobe = 1'b1;
                            if (r_fill == FULL_CNT) begin
                                n_res.status = 1'b1;
                            end else begin
                                wr_en   = 1'b1;
                                wr_addr = r_fill[AW-1:0];
                                wr_data = i_item.value;
                                n_fill  = r_fill + CW'(1);
                            end
                        end
                        CMD_SORT: begin
                            if (r_fill < CW'(2)) begin
                                n_strobe = 1'b1;
                            end else begin
                                n_lim   = fill_m1[AW-1:0];
                                n_idx   = '0;
                                rd_addr = '0;
                                n_state = S_SLOAD;
                            end
                        end
                        CMD_SEARCH: begin
                            if (r_fill == '0) begin
                                n_strobe = 1'b1;
                            end else begin
                                n_opnd  = i_item.value;
                                n_lo    = '0;
                                n_hi    = r_fill;
                                n_state = S_PROBE;
                            end
                        end
                    endcase
                end
            end
            S_SLOAD: begin
                n_opnd  = r_rdata;
                n_swap  = 1'b0;
                rd_addr = idx_nx;
                n_state = S_SCMP;
            end
            S_SCMP: begin
                if (cmp.gt) begin
                    wr_en   = 1'b1;
                    wr_addr = r_idx;
                    wr_data = r_rdata;
                    n_swap  = 1'b1;
                end else begin
                    wr_en   = 1'b1;
                    wr_addr = r_idx;
                    wr_data = r_opnd;
                    n_opnd  = r_rdata;
                end
                if (idx_nx == r_lim) begin
                    n_state = S_SEND;
                end else begin
                    rd_addr = idx_nx + AW'(1);
                    n_idx   = idx_nx;
                end
            end
            S_SEND: begin
                wr_en   = 1'b1;
                wr_addr = r_lim;
                wr_data = r_opnd;
                if (!r_swap || r_lim == AW'(1)) begin
                    n_strobe = 1'b1;
                    n_state  = S_IDLE;
                end else begin
                    n_lim   = r_lim - AW'(1);
                    n_idx   = '0;
                    rd_addr = '0;
                    n_state = S_SLOAD;
                end
            end
            S_PROBE: begin
                n_mid   = mid_sum[AW:1];
                rd_addr = mid_sum[AW:1];
                n_state = S_PCMP;
            end
            S_PCMP: begin
                if (cmp.eq) begin
                    n_res.found = 1'b1;
                    n_strobe    = 1'b1;
                    n_state     = S_IDLE;
                end else if (!cmp.gt) begin
                    n_hi = CW'(r_mid);
                    if (r_lo < CW'(r_mid)) begin
                        n_state = S_PROBE;
                    end else begin
                        n_strobe = 1'b1;
                        n_state  = S_IDLE;
                    end
                end else begin
                    n_lo = lo_nx;
                    if (lo_nx < r_hi) begin
                        n_state = S_PROBE;
                    end else begin
                        n_strobe = 1'b1;
                        n_state  = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_fill   <= '0;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_fill   <= n_fill;
            r_strobe <= n_strobe;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx  <= n_idx;
        r_lim  <= n_lim;
        r_mid  <= n_mid;
        r_lo   <= n_lo;
        r_hi   <= n_hi;
        r_opnd <= n_opnd;
        r_swap <= n_swap;
        r_res  <= n_res;
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        r_rdata <= mem[rd_addr];
    end

    assign busy     = (r_state != S_IDLE);
    assign o_strobe = r_strobe;
    assign o_result = r_res;

endmodule

### hw/rtl/sts_cmp.sv
// ---------------------------------------------------------------------------
// sts_cmp
// Shared signed comparator used by both the sort and the search sequence.
// ---------------------------------------------------------------------------
module sts_cmp
    import sts_pkg::*;
(
    input  logic signed [DATA_W-1:0] i_a,
    input  logic signed [DATA_W-1:0] i_b,
    output t_cmp                     o_cmp
);

    assign o_cmp.eq = (i_a == i_b);
    assign o_cmp.gt = (i_a > i_b);

endmodule

### hw/rtl/sts_chk.sv
// ---------------------------------------------------------------------------
// sts_chk
// Port-level checker of the sorted table search block, bound to the top.
// ---------------------------------------------------------------------------
`include "sorted_table_search_top_assert.svh"

module sts_chk
    import sts_pkg::*;
(
    input logic    i_clk,
    input logic    i_rst_n,
    input logic    start,
    input logic    busy,
    input t_item   i_item,
    input logic    o_strobe,
    input t_result o_result
);

    logic acc;
    assign acc = start && !busy;

    `STS_ASSERT_SAME(a_strobe_idle, i_clk, i_rst_n, o_strobe, !busy)
    `STS_ASSERT_SAME(a_flags_excl, i_clk, i_rst_n, o_strobe, !(o_result.found && o_result.status))
    `STS_ASSERT_NEXT(a_quick_cmd, i_clk, i_rst_n, acc && (i_item.cmd == CMD_CLEAR || i_item.cmd == CMD_INSERT), o_strobe && !o_result.found && !busy)
    `STS_ASSERT_SAME(a_strobe_cause, i_clk, i_rst_n, o_strobe, $past(busy) || $past(acc))

endmodule

bind sorted_table_search_top sts_chk u_sts_chk (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .start    (start),
    .busy     (busy),
    .i_item   (i_item),
    .o_strobe (o_strobe),
    .o_result (o_result)
);
